FILE: sv/atan2ma_pkg.sv
// types, fixed-point constants and helpers shared by the atan2 core and its checker
package atan2ma_pkg;

  localparam int QF        = 30;
  localparam int QW        = 31;
  localparam int DIV_STEPS = 31;
  localparam int N_STAGES  = 2 + DIV_STEPS + 10;

  localparam logic [QW-1:0] ONE_Q     = 31'h4000_0000;
  localparam logic [QW-1:0] K_C1      = 31'd26672053;
  localparam logic [QW-1:0] K_C2      = 31'd200590198;
  localparam logic [QW-1:0] K_C3      = 31'd101036902;
  localparam logic [QW-1:0] K_C4      = 31'd356622645;
  localparam logic [31:0]   PI_Q      = 32'd3373259426;
  localparam logic [31:0]   HALF_PI_Q = 32'd1686629713;

  typedef struct packed {
    logic swap;
    logic xneg;
    logic yneg;
    logic zero;
  } quad_t;

  // q30 product of two non-negative values, rounded to nearest
  function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << (QF - 1));
    return p[60:30];
  endfunction

  // clamp a signed q30 value to [0, pi]
  function automatic logic [31:0] clamp_pi(input logic signed [33:0] v);
    logic [31:0] r;
    if (v < 34'sd0) begin
      r = '0;
    end else if (v > $signed({2'b00, PI_Q})) begin
      r = PI_Q;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/atan2_minimax_approx_core.sv
// four-quadrant arctangent core: pipelined divider and minimax polynomial
// Takes one (x, y) request per clock and returns atan2(y, x) in radians as Q3.OUT_FRAC
// two's complement, saturated to +/- pi, with (0,0) giving 0. From acceptance to out_tvalid
// a request passes two entry stages, a 31-stage restoring divider that resolves
// one quotient bit per stage, and ten stages for the polynomial multiplies and quadrant
// mapping. Sustained rate is one request per clock while out_tready stays high; a stall
// halts the whole pipeline, one more request is caught in an input skid register, and the
// first cycle after the stall drains that register with in_tready low.
module atan2_minimax_approx_core
  import atan2ma_pkg::*;
#(
  parameter int IN_WIDTH = 16,
  parameter int OUT_FRAC = 13,
  localparam int IN_TDW  = ((2 * IN_WIDTH + 7) / 8) * 8,
  localparam int OUT_W   = OUT_FRAC + 3,
  localparam int OUT_TDW = ((OUT_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_TDW-1:0]  in_tdata,   // x_in, y_in
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_TDW-1:0] out_tdata   // angle
);

  localparam int W  = IN_WIDTH;
  localparam int SH = QF - OUT_FRAC;
  localparam logic [32:0] LIM = 33'((64'(PI_Q) + (64'd1 << (SH - 1))) >> SH);

  logic adv;
  logic in_fire;
  logic src_v;
  logic [N_STAGES-1:0] v_r;

  logic            skid_v_r;
  logic [2*W-1:0]  skid_d_r;
  logic [2*W-1:0]  src_d;

  assign adv       = ~v_r[N_STAGES-1] | out_tready;
  assign in_tready = ~skid_v_r;
  assign in_fire   = in_tvalid & in_tready;
  assign src_v     = skid_v_r | in_fire;
  assign src_d     = skid_v_r ? skid_d_r : in_tdata[2*W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      v_r      <= '0;
    end else begin
      if (adv) begin
        skid_v_r <= 1'b0;
        v_r      <= {v_r[N_STAGES-2:0], src_v};
      end else if (in_fire) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_fire) begin
      skid_d_r <= in_tdata[2*W-1:0];
    end
  end

  // stage a: magnitudes, ordering, quadrant flags
  logic [W-1:0] sx, sy, ax, ay;
  logic         swp;
  logic [W-1:0] sa_mx_r, sa_mn_r;
  quad_t        sa_f_r;

  assign sx  = src_d[W-1:0];
  assign sy  = src_d[2*W-1:W];
  assign ax  = sx[W-1] ? (~sx + W'(1)) : sx;
  assign ay  = sy[W-1] ? (~sy + W'(1)) : sy;
  assign swp = ay > ax;

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_mx_r     <= swp ? ay : ax;
      sa_mn_r     <= swp ? ax : ay;
      sa_f_r.swap <= swp;
      sa_f_r.xneg <= sx[W-1];
      sa_f_r.yneg <= sy[W-1];
      sa_f_r.zero <= (ax == '0) && (ay == '0);
    end
  end

  // stage b and divider: (mn * 2^30 + mx/2) / mx, one quotient bit per stage
  logic [W+30:0] num;
  logic [W-1:0]  div_rem_r [0:DIV_STEPS];
  logic [QW-1:0] div_nq_r  [0:DIV_STEPS];
  logic [W-1:0]  div_mx_r  [0:DIV_STEPS];
  quad_t         div_f_r   [0:DIV_STEPS];

  assign num = {1'b0, sa_mn_r, 30'b0} + (W+31)'(sa_mx_r >> 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      div_rem_r[0] <= num[W+30:31];
      div_nq_r[0]  <= num[30:0];
      div_mx_r[0]  <= sa_mx_r;
      div_f_r[0]   <= sa_f_r;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [W:0] trial;
    logic       ge;
    assign trial = {div_rem_r[k-1], div_nq_r[k-1][QW-1]};
    assign ge    = trial >= {1'b0, div_mx_r[k-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        div_rem_r[k] <= ge ? W'(trial - {1'b0, div_mx_r[k-1]}) : trial[W-1:0];
        div_nq_r[k]  <= {div_nq_r[k-1][QW-2:0], ge};
        div_mx_r[k]  <= div_mx_r[k-1];
        div_f_r[k]   <= div_f_r[k-1];
      end
    end
  end

  // polynomial stages
  logic [QW-1:0] qa;
  logic [QW-1:0] m1_a_r, m1_s_r;
  quad_t         m1_f_r;
  logic [QW-1:0] m2_a_r, m2_s_r, m2_c_r, m2_q_r;
  quad_t         m2_f_r;
  logic [QW-1:0] m3_a_r, m3_s_r, m3_c_r, m3_p1_r, m3_p3_r;
  quad_t         m3_f_r;
  logic [QW-1:0] m4_a_r, m4_c_r, m4_p3_r, m4_p4_r;
  quad_t         m4_f_r;
  logic [QW-1:0] m5_a_r, m5_c_r, m5_m_r;
  quad_t         m5_f_r;
  logic [QW-1:0] m6_a_r, m6_p5_r;
  quad_t         m6_f_r;
  logic [31:0]   m7_r_r, m8_r_r, m9_r_r;
  quad_t         m7_f_r, m8_f_r, m9_f_r;
  logic [OUT_W-1:0] out_angle_r;

  logic [QW-1:0] r1;
  logic [31:0]   msum;
  logic [33:0]   rnd;
  logic [32:0]   mag;
  logic [32:0]   mag_lim;

  assign qa      = (div_nq_r[DIV_STEPS] > ONE_Q) ? ONE_Q : div_nq_r[DIV_STEPS];
  assign r1      = m3_p1_r + K_C2;
  assign msum    = 32'(K_C4) + 32'(m4_p3_r) - 32'(m4_p4_r);
  assign rnd     = {2'b00, m9_r_r} + (34'd1 << (SH - 1));
  assign mag     = 33'(rnd >> SH);
  assign mag_lim = (mag > LIM) ? LIM : mag;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_a_r  <= qa;
      m1_s_r  <= qmul(qa, qa);
      m1_f_r  <= div_f_r[DIV_STEPS];

      m2_a_r  <= m1_a_r;
      m2_s_r  <= m1_s_r;
      m2_c_r  <= qmul(m1_s_r, m1_a_r);
      m2_q_r  <= qmul(m1_s_r, m1_s_r);
      m2_f_r  <= m1_f_r;

      m3_a_r  <= m2_a_r;
      m3_s_r  <= m2_s_r;
      m3_c_r  <= m2_c_r;
      m3_p1_r <= qmul(K_C1, m2_q_r);
      m3_p3_r <= qmul(K_C3, m2_q_r);
      m3_f_r  <= m2_f_r;

      m4_a_r  <= m3_a_r;
      m4_c_r  <= m3_c_r;
      m4_p3_r <= m3_p3_r;
      m4_p4_r <= qmul(r1, m3_s_r);
      m4_f_r  <= m3_f_r;

      // magnitude of the negative inner term
      m5_a_r  <= m4_a_r;
      m5_c_r  <= m4_c_r;
      m5_m_r  <= msum[QW-1:0];
      m5_f_r  <= m4_f_r;

      m6_a_r  <= m5_a_r;
      m6_p5_r <= qmul(m5_m_r, m5_c_r);
      m6_f_r  <= m5_f_r;

      m7_r_r  <= clamp_pi($signed({3'b000, m6_a_r}) - $signed({3'b000, m6_p5_r}));
      m7_f_r  <= m6_f_r;

      m8_r_r  <= m7_f_r.swap
                 ? clamp_pi($signed({2'b00, HALF_PI_Q}) - $signed({2'b00, m7_r_r}))
                 : m7_r_r;
      m8_f_r  <= m7_f_r;

      m9_r_r  <= m8_f_r.xneg
                 ? clamp_pi($signed({2'b00, PI_Q}) - $signed({2'b00, m8_r_r}))
                 : m8_r_r;
      m9_f_r  <= m8_f_r;

      if (m9_f_r.zero) begin
        out_angle_r <= '0;
      end else if (m9_f_r.yneg) begin
        out_angle_r <= OUT_W'(~mag_lim + 33'd1);
      end else begin
        out_angle_r <= OUT_W'(mag_lim);
      end
    end
  end

  assign out_tvalid = v_r[N_STAGES-1];
  assign out_tdata  = OUT_TDW'(out_angle_r);

endmodule

FILE: sv/atan2ma_checker.sv
// port-level checker for the atan2 core, bound into the core module
module atan2ma_checker
  import atan2ma_pkg::*;
#(
  parameter int IN_WIDTH = 16,
  parameter int OUT_FRAC = 13,
  localparam int IN_TDW  = ((2 * IN_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDW = ((OUT_FRAC + 3 + 7) / 8) * 8
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic [IN_TDW-1:0]  in_tdata,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_TDW-1:0] out_tdata
);

  logic       in_acc, out_acc;
  logic [6:0] cnt_r;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  // requests in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 7'(in_acc) - 7'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> cnt_r != 7'd0)
    else $error("result delivered with no request in flight");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 7'(N_STAGES + 1))
    else $error("more requests in flight than the pipeline holds");

  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input blocked without an output stall");

  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  logic unused_in;
  assign unused_in = ^in_tdata;

endmodule

bind atan2_minimax_approx_core atan2ma_checker #(
  .IN_WIDTH(IN_WIDTH),
  .OUT_FRAC(OUT_FRAC)
) u_atan2ma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

FILE: test/tb_atan2_minimax_approx_core.sv
// testbench for the four-quadrant arctangent core: directed, full-rate, stall and random vectors
module tb_atan2_minimax_approx_core;
  import atan2ma_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_WAIT  = 60;
  localparam int     STALL_LEN   = 300;
  localparam longint Q30_HALF    = 64'd536870912;
  localparam longint Q30_ONE     = 64'd1073741824;
  localparam longint COEF_A4A6   = 64'd26672053;
  localparam longint COEF_A2     = 64'd200590198;
  localparam longint COEF_A4     = 64'd101036902;
  localparam longint COEF_A0     = 64'd356622645;
  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam int     OUT_SHIFT   = 17;
  localparam int     CORNER_VALS[6] = '{-32768, -32767, -1, 0, 1, 32767};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // x_in, y_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // angle

  logic [15:0] angle_q[$];
  int          fail_count  = 0;
  int          sent_count  = 0;
  int          angle_count = 0;
  int          cycle_count = 0;
  bit          src_gaps    = 1'b1;
  bit          sink_gaps   = 1'b1;
  int          hold_req    = 0;
  int          hold_ack    = 0;
  int          hold_left   = 0;

  atan2_minimax_approx_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint q30_product(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) begin
      return (p + Q30_HALF) >>> 30;
    end
    return -((-p + Q30_HALF) >>> 30);
  endfunction

  function automatic longint clamp_half_turn(longint v);
    if (v < 0) begin
      return 0;
    end else if (v > PI_Q30) begin
      return PI_Q30;
    end
    return v;
  endfunction

  function automatic logic [15:0] predict_angle(logic signed [15:0] x, logic signed [15:0] y);
    longint ax, ay, big, lil, a, s, c, q, r, t, mag, lim;
    bit     xn, yn;
    xn  = (x < 0);
    yn  = (y < 0);
    ax  = xn ? -longint'(x) : longint'(x);
    ay  = yn ? -longint'(y) : longint'(y);
    big = (ay > ax) ? ay : ax;
    lil = (ay > ax) ? ax : ay;
    if (big == 0) begin
      return 16'd0;
    end
    a = ((lil <<< 30) + (big >>> 1)) / big;
    if (a > Q30_ONE) begin
      a = Q30_ONE;
    end
    s = q30_product(a, a);
    c = q30_product(s, a);
    q = q30_product(s, s);
    r = q30_product(COEF_A4A6, q) + COEF_A2;
    t = -q30_product(COEF_A4, q) - COEF_A0;
    r = q30_product(r, s) + t;
    r = clamp_half_turn(q30_product(r, c) + a);
    if (ay > ax) begin
      r = clamp_half_turn(HALF_PI_Q30 - r);
    end
    if (xn) begin
      r = clamp_half_turn(PI_Q30 - r);
    end
    mag = (r + (64'd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    lim = (PI_Q30 + (64'd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (mag > lim) begin
      mag = lim;
    end
    return 16'(yn ? -mag : mag);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("atan2_minimax_approx_core test failed");
      $finish;
    end
  end

  // result side: checks each angle, random stalls and long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        angle_count++;
        if (angle_q.size() == 0) begin
          $error("unexpected angle: actual %0d", $signed(out_tdata));
          fail_count++;
        end else begin
          logic [15:0] want;
          want = angle_q.pop_front();
          if (out_tdata !== want) begin
            $error("angle mismatch: expected %0d actual %0d", $signed(want), $signed(out_tdata));
            fail_count++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = STALL_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(sink_gaps && ($urandom_range(99) < 26));
      end
    end
  end

  task automatic send_vector(input logic [15:0] x, input logic [15:0] y);
    while (src_gaps && ($urandom_range(99) < 26)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
    angle_q.push_back(predict_angle(x, y));
    sent_count++;
  endtask

  task automatic wait_all_angles();
    in_tvalid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_vector(16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0);
    send_vector(-16'sd1, 16'sd0);
    send_vector(-16'sd5, 16'sd0);
    send_vector(16'sd0, 16'sd1);
    send_vector(16'sd0, -16'sd1);
    send_vector(16'sd32767, 16'sd0);
    send_vector(-16'sd32768, 16'sd0);
    send_vector(16'sd0, -16'sd32768);
    send_vector(16'sd0, 16'sd32767);
    send_vector(16'sd100, 16'sd100);
    send_vector(-16'sd100, 16'sd100);
    send_vector(-16'sd100, -16'sd100);
    send_vector(16'sd100, -16'sd100);
    send_vector(-16'sd32768, -16'sd32768);
    send_vector(16'sd32767, 16'sd32767);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, 16'sd32767);
    send_vector(16'sd1, 16'sd32767);
    send_vector(16'sd32767, 16'sd1);
    send_vector(-16'sd1, -16'sd32768);
    send_vector(-16'sd32768, 16'sd1);
    wait_all_angles();
  endtask

  task automatic random_vector();
    int xi, yi;
    case ($urandom_range(0, 9))
      4: begin
        xi = $urandom_range(0, 8) - 4;
        yi = $urandom_range(0, 8) - 4;
      end
      5: begin
        xi = $urandom_range(0, 32767);
        yi = xi + $urandom_range(0, 2) - 1;
        if (yi > 32767) yi = 32767;
        if (yi < 0) yi = 0;
        if ($urandom_range(1)) xi = -xi;
        if ($urandom_range(1)) yi = -yi;
      end
      6: begin
        xi = $signed(16'($urandom));
        yi = 0;
        if ($urandom_range(1)) begin
          yi = xi;
          xi = 0;
        end
      end
      7: begin
        xi = CORNER_VALS[$urandom_range(0, 5)];
        yi = CORNER_VALS[$urandom_range(0, 5)];
      end
      8: begin
        xi = $signed(16'($urandom));
        yi = $urandom_range(0, 6) - 3;
        if ($urandom_range(1)) begin
          yi = xi;
          xi = $urandom_range(0, 6) - 3;
        end
      end
      default: begin
        xi = $signed(16'($urandom));
        yi = $signed(16'($urandom));
      end
    endcase
    send_vector(16'(xi), 16'(yi));
  endtask

  task automatic test_full_rate();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    repeat (200) random_vector();
    wait_all_angles();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    hold_req <= hold_req + 1;
    repeat (120) random_vector();
    src_gaps = 1'b1;
    wait_all_angles();
  endtask

  task automatic test_random();
    repeat (700) random_vector();
    wait_all_angles();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_rate();
    test_backpressure();
    test_random();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (angle_q.size() != 0) begin
      $error("%0d angles never arrived", angle_q.size());
      fail_count++;
    end
    $display("sent %0d vectors (axes, diagonals, extremes, random), checked %0d angles",
             sent_count, angle_count);
    $display("covered full-rate streaming, a %0d-cycle output hold-off and random gaps",
             STALL_LEN);
    if (fail_count == 0) begin
      $display("atan2_minimax_approx_core test passed");
    end else begin
      $display("atan2_minimax_approx_core test failed");
    end
    $finish;
  end

endmodule
